### src/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising clock edge out of reset
`define BPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// shared widths, sequencer steps and the command/status bundles
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int unsigned PAGES     = 4096;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned ORD_W     = 4;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned TOP_ORDER = 10;
  localparam int unsigned NUM_LISTS = TOP_ORDER + 1;

  localparam logic [ORD_W-1:0] TOP_ORD = ORD_W'(TOP_ORDER);

  // action codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_REM,
    S_REM_RD,
    S_REM_WR,
    S_SPLIT,
    S_PUSH,
    S_PUSH_RD,
    S_PUSH_WR,
    S_A_FIN,
    S_FAIL,
    S_F_RD,
    S_F_LOOP,
    S_F_CHK,
    S_F_MERGE,
    S_DONE
  } bpa_state_e;

  typedef struct packed {
    logic             taken;
    logic [ORD_W-1:0] order;
  } bpa_meta_t;

  typedef struct packed {
    bpa_state_e step;
    logic       in_ready;
  } bpa_cmd_t;

  typedef struct packed {
    logic act;        // current item is a free
    logic req_bad;    // requested order above the top list
    logic found;      // some list at or above the request holds a block
    logic pidx_oob;   // freed page outside the pool
    logic cnt_zero;   // list of the current order is empty
    logic cnt_one;    // list of the current order holds one block
    logic split_more; // split has not reached the requested order
    logic split_in;   // upper half of the split lies inside the pool
    logic buddy_ok;   // merge buddy exists and lies inside the pool
    logic merge_ok;   // buddy is free at the same order
    logic out_free;   // result register can take a new result
    logic clr_last;   // last entry of the clearing pass
  } bpa_status_t;

endpackage

### src/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator
// binary buddy allocator over a pool of up to 4096 pages
// ----------------------------------------------------------------------------
// One request per item on the slave stream: tuser selects allocate (0) or
// free (1); tdata carries the requested order and the page to free. Each
// item returns one result with a fail flag, the block's first page and the
// pool's free page total. After reset a clearing pass marks every page
// taken at order 0 (tready stays low, the register port works); software
// then frees each page. A failed request is the shortest item and a free
// that merges across all ten orders the longest: each round of the split
// or merge loop does a few read-modify-writes on the one-read one-write
// page metadata and link memories, and a list remove or push adds its own
// read and write steps. One item is worked at a time; the finished result
// sits in an output register while the next item is taken.
// ----------------------------------------------------------------------------
module buddy_page_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // order [3:0], page_index [15:4]
  input  logic        s_axis_tuser,   // action
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // block_index [11:0], free_pages [24:12], zero above
  output logic        m_axis_tuser,   // status
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bpa_pkg::*;

  `include "assert_macros.svh"

  logic [CNT_W-1:0] pool_pages_q;
  bpa_cmd_t         cmd;
  bpa_status_t      status;
  logic [IDX_W-1:0] out_block;
  logic [CNT_W-1:0] out_free;

  // pool_pages sits at byte address 0
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-CNT_W){1'b0}}, pool_pages_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_pages_q <= CNT_W'(PAGES);
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      pool_pages_q <= pwdata[CNT_W-1:0];
    end
  end

  bpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bpa_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_act_i     (s_axis_tuser),
    .in_order_i   (s_axis_tdata[3:0]),
    .in_page_i    (s_axis_tdata[15:4]),
    .pool_pages_i (pool_pages_q),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (m_axis_tuser),
    .out_block_o  (out_block),
    .out_free_o   (out_free)
  );

  assign s_axis_tready = cmd.in_ready;
  assign m_axis_tdata  = {7'd0, out_free, out_block};

  // one item at a time: no new item right after one is taken
  `BPA_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready,
                   "second item accepted while one is in work")
  // a result never appears the cycle after its item is taken
  `BPA_ASSERT_NEXT(a_no_early_result, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid),
                   "result raised too early")
  // no item is taken while the clearing pass runs
  `BPA_ASSERT_NOW(a_clear_blocks_input, cmd.step == S_CLEAR, !s_axis_tready,
                  "item accepted during clearing pass")

endmodule

### src/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// sequencer that steps the datapath through alloc, free, split and merge
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  bpa_pkg::bpa_status_t status_i,
  output bpa_pkg::bpa_cmd_t    cmd_o
);
  import bpa_pkg::*;

  bpa_state_e state_q, state_d;
  bpa_state_e ret_rem, ret_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // where a list remove or push returns to
  assign ret_rem  = status_i.act ? S_F_MERGE : S_SPLIT;
  assign ret_push = status_i.act ? S_DONE : S_SPLIT;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:   if (status_i.clr_last) state_d = S_IDLE;
      S_IDLE:    if (in_valid_i) state_d = S_START;
      S_START: begin
        if (status_i.act) begin
          state_d = status_i.pidx_oob ? S_FAIL : S_F_RD;
        end else begin
          state_d = (status_i.req_bad || !status_i.found) ? S_FAIL : S_REM;
        end
      end
      S_REM:     state_d = (status_i.cnt_zero || status_i.cnt_one) ? ret_rem : S_REM_RD;
      S_REM_RD:  state_d = S_REM_WR;
      S_REM_WR:  state_d = ret_rem;
      S_SPLIT: begin
        if (!status_i.split_more) begin
          state_d = S_A_FIN;
        end else if (status_i.split_in) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH:    state_d = status_i.cnt_zero ? ret_push : S_PUSH_RD;
      S_PUSH_RD: state_d = S_PUSH_WR;
      S_PUSH_WR: state_d = ret_push;
      S_A_FIN:   state_d = S_DONE;
      S_FAIL:    state_d = S_DONE;
      S_F_RD:    state_d = S_F_LOOP;
      S_F_LOOP:  state_d = status_i.buddy_ok ? S_F_CHK : S_PUSH;
      S_F_CHK:   state_d = status_i.merge_ok ? S_REM : S_PUSH;
      S_F_MERGE: state_d = S_F_LOOP;
      S_DONE:    if (status_i.out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.step     = state_q;
    cmd_o.in_ready = (state_q == S_IDLE);
  end

endmodule

### src/bpa_datapath.sv
// ----------------------------------------------------------------------------
// bpa_datapath
// page metadata and link memories, list heads and counts, result register
// ----------------------------------------------------------------------------
module bpa_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bpa_pkg::bpa_cmd_t           cmd_i,
  output bpa_pkg::bpa_status_t        status_o,
  input  logic                        in_act_i,
  input  logic [bpa_pkg::ORD_W-1:0]   in_order_i,
  input  logic [bpa_pkg::IDX_W-1:0]   in_page_i,
  input  logic [bpa_pkg::CNT_W-1:0]   pool_pages_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic                        out_status_o,
  output logic [bpa_pkg::IDX_W-1:0]   out_block_o,
  output logic [bpa_pkg::CNT_W-1:0]   out_free_o
);
  import bpa_pkg::*;

  // memories
  bpa_meta_t        meta_mem [PAGES];
  logic [IDX_W-1:0] next_mem [PAGES];
  logic [IDX_W-1:0] prev_mem [PAGES];

  bpa_meta_t        meta_rd_q;
  logic [IDX_W-1:0] next_rd_q, prev_rd_q;

  logic [IDX_W-1:0] raddr;
  logic             meta_we, nx_we, pv_we;
  logic [IDX_W-1:0] meta_wa, nx_wa, pv_wa, nx_wd, pv_wd;
  bpa_meta_t        meta_wd;

  // working registers
  logic             act_q, fail_q;
  logic [ORD_W-1:0] req_q, o_q;
  logic [IDX_W-1:0] pidx_q, x_q, b_q, h_q, t_q, n_q, p_q;
  logic [CNT_W-1:0] total_q;
  logic [IDX_W-1:0] head_q [NUM_LISTS];
  logic [CNT_W-1:0] cnt_q  [NUM_LISTS];
  logic [IDX_W-1:0] clr_q;
  logic             out_valid_q, out_status_q;
  logic [IDX_W-1:0] out_block_q;
  logic [CNT_W-1:0] out_free_q;

  logic [CNT_W-1:0] limit;
  logic             found, out_free;
  logic [ORD_W-1:0] found_ord, new_o, merge_o, f_ord;
  logic [IDX_W-1:0] split_b, fb, merge_x, elem_rem, elem_push;

  assign limit = (pool_pages_i > CNT_W'(PAGES)) ? CNT_W'(PAGES) : pool_pages_i;

  // lowest non-empty list at or above the request
  always_comb begin
    found     = 1'b0;
    found_ord = '0;
    for (int i = NUM_LISTS - 1; i >= 0; i--) begin
      if (ORD_W'(i) >= req_q && cnt_q[i] != '0) begin
        found     = 1'b1;
        found_ord = ORD_W'(i);
      end
    end
  end

  assign new_o     = o_q - ORD_W'(1);
  assign split_b   = x_q ^ (IDX_W'(1) << new_o);
  assign fb        = x_q ^ (IDX_W'(1) << o_q);
  assign merge_x   = (b_q < x_q) ? b_q : x_q;
  assign merge_o   = o_q + ORD_W'(1);
  assign f_ord     = (meta_rd_q.order > TOP_ORD) ? TOP_ORD : meta_rd_q.order;
  assign elem_rem  = act_q ? b_q : x_q;
  assign elem_push = act_q ? x_q : b_q;
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    status_o.act        = act_q;
    status_o.req_bad    = req_q > TOP_ORD;
    status_o.found      = found;
    status_o.pidx_oob   = {1'b0, pidx_q} >= limit;
    status_o.cnt_zero   = cnt_q[o_q] == '0;
    status_o.cnt_one    = cnt_q[o_q] == CNT_W'(1);
    status_o.split_more = o_q > req_q;
    status_o.split_in   = {1'b0, split_b} < limit;
    status_o.buddy_ok   = (o_q < TOP_ORD) && ({1'b0, fb} < limit);
    status_o.merge_ok   = !meta_rd_q.taken && (meta_rd_q.order == o_q);
    status_o.out_free   = out_free;
    status_o.clr_last   = &clr_q;
  end

  // memory port control
  always_comb begin
    raddr   = x_q;
    meta_we = 1'b0;
    meta_wa = x_q;
    meta_wd = '0;
    nx_we   = 1'b0;
    nx_wa   = elem_push;
    nx_wd   = elem_push;
    pv_we   = 1'b0;
    pv_wa   = elem_push;
    pv_wd   = elem_push;
    case (cmd_i.step)
      S_CLEAR: begin
        meta_we = 1'b1;
        meta_wa = clr_q;
        meta_wd = '{taken: 1'b1, order: '0};
      end
      S_START: raddr = pidx_q;
      S_REM:   raddr = elem_rem;
      S_REM_WR: begin
        nx_we = 1'b1;
        nx_wa = p_q;
        nx_wd = n_q;
        pv_we = 1'b1;
        pv_wa = n_q;
        pv_wd = p_q;
      end
      S_SPLIT: begin
        meta_we = status_o.split_more && status_o.split_in;
        meta_wa = split_b;
        meta_wd = '{taken: 1'b0, order: new_o};
      end
      S_PUSH: begin
        raddr = head_q[o_q];
        nx_we = status_o.cnt_zero;
        pv_we = status_o.cnt_zero;
      end
      S_PUSH_RD: begin
        nx_we = 1'b1;
        nx_wd = h_q;
        pv_we = 1'b1;
        pv_wd = prev_rd_q;
      end
      S_PUSH_WR: begin
        nx_we = 1'b1;
        nx_wa = t_q;
        pv_we = 1'b1;
        pv_wa = h_q;
      end
      S_A_FIN: begin
        meta_we = 1'b1;
        meta_wd = '{taken: 1'b1, order: req_q};
      end
      S_F_RD: begin
        meta_we = 1'b1;
        meta_wd = '{taken: 1'b0, order: meta_rd_q.order};
      end
      S_F_LOOP: raddr = fb;
      S_F_MERGE: begin
        meta_we = 1'b1;
        meta_wa = merge_x;
        meta_wd = '{taken: 1'b0, order: merge_o};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    if (nx_we)   next_mem[nx_wa]   <= nx_wd;
    if (pv_we)   prev_mem[pv_wa]   <= pv_wd;
  end

  always_ff @(posedge clk_i) begin
    meta_rd_q <= meta_mem[raddr];
    next_rd_q <= next_mem[raddr];
    prev_rd_q <= prev_mem[raddr];
  end

  // control state: counts, free total, clearing pointer, fail and result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LISTS; i++) cnt_q[i] <= '0;
      total_q     <= '0;
      clr_q       <= '0;
      fail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i.step)
        S_CLEAR: clr_q  <= clr_q + IDX_W'(1);
        S_IDLE:  fail_q <= 1'b0;
        S_REM: begin
          if (!status_o.cnt_zero && status_o.cnt_one) cnt_q[o_q] <= cnt_q[o_q] - CNT_W'(1);
        end
        S_REM_WR:  cnt_q[o_q] <= cnt_q[o_q] - CNT_W'(1);
        S_PUSH:    if (status_o.cnt_zero) cnt_q[o_q] <= cnt_q[o_q] + CNT_W'(1);
        S_PUSH_WR: cnt_q[o_q] <= cnt_q[o_q] + CNT_W'(1);
        S_A_FIN:   total_q <= total_q - (CNT_W'(1) << req_q);
        S_FAIL:    fail_q <= 1'b1;
        S_F_RD:    total_q <= total_q + (CNT_W'(1) << f_ord);
        default: ;
      endcase
      if (cmd_i.step == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.step)
      S_IDLE: begin
        act_q  <= in_act_i;
        req_q  <= in_order_i;
        pidx_q <= in_page_i;
      end
      S_START: begin
        if (act_q == ACT_ALLOC) begin
          x_q <= head_q[found_ord];
          o_q <= found_ord;
        end else begin
          x_q <= pidx_q;
        end
      end
      S_REM_RD: begin
        n_q <= next_rd_q;
        p_q <= prev_rd_q;
      end
      S_REM_WR: if (head_q[o_q] == elem_rem) head_q[o_q] <= n_q;
      S_SPLIT: begin
        if (status_o.split_more) begin
          o_q <= new_o;
          b_q <= split_b;
        end
      end
      S_PUSH: begin
        h_q <= head_q[o_q];
        if (status_o.cnt_zero) head_q[o_q] <= elem_push;
      end
      S_PUSH_RD: t_q <= prev_rd_q;
      S_PUSH_WR: head_q[o_q] <= elem_push;
      S_F_RD:    o_q <= f_ord;
      S_F_LOOP:  b_q <= fb;
      S_F_MERGE: begin
        x_q <= merge_x;
        o_q <= merge_o;
      end
      S_DONE: begin
        if (out_free) begin
          out_status_q <= fail_q;
          out_block_q  <= fail_q ? (act_q ? pidx_q : '0) : x_q;
          out_free_q   <= total_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_block_o  = out_block_q;
  assign out_free_o   = out_free_q;

endmodule
